FILE: rtl/core/spim_pkg.sv
// Shared constants, types and helpers for the SPI master with byte FIFOs.
`default_nettype none

package spim_pkg;

    // FIFO geometry
    localparam int FifoDepth = 8;
    localparam int PtrW      = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
    localparam int CntW      = $clog2(FifoDepth + 1);
    localparam int SumW      = $clog2(2 * FifoDepth);

    // Field widths
    localparam int OpW      = 2;
    localparam int RegW     = 2;
    localparam int ByteW    = 8;
    localparam int ReadW    = 18;
    localparam int HalfW    = 16;
    localparam int BitCntW  = 4;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;

    localparam int BitsPerByte = 8;

    // Opcodes of an input item
    localparam logic [OpW-1:0] OP_TICK  = 2'd0;
    localparam logic [OpW-1:0] OP_READ  = 2'd1;
    localparam logic [OpW-1:0] OP_WRITE = 2'd2;

    // Register map of the bus side
    localparam logic [RegW-1:0] REG_DATA   = 2'd0;
    localparam logic [RegW-1:0] REG_STATUS = 2'd1;
    localparam logic [RegW-1:0] REG_FLUSH  = 2'd2;
    localparam logic [RegW-1:0] REG_CONFIG = 2'd3;

    // Configuration port indexes
    localparam logic [CfgIdxW-1:0] CFG_CPOL = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_CPHA = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_HALF = 2'd2;

    // Status register bit positions
    localparam int ST_TXE = 4;
    localparam int ST_TXF = 3;
    localparam int ST_RXE = 2;
    localparam int ST_RXF = 1;
    localparam int ST_CS  = 0;

    // Flush register bit positions
    localparam int FL_TX = 1;
    localparam int FL_RX = 0;

    // Classified command handed from front to back
    typedef enum logic [2:0] {
        KIND_TICK,
        KIND_RD_DATA,
        KIND_RD_STATUS,
        KIND_RD_CFG,
        KIND_WR_DATA,
        KIND_WR_STATUS,
        KIND_WR_FLUSH,
        KIND_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [ByteW-1:0] data;
        logic             miso;
    } cmd_t;

    // Circular pointer increment
    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        logic [PtrW-1:0] r;
        if (p == PtrW'(FifoDepth - 1)) r = '0;
        else                           r = p + PtrW'(1);
        return r;
    endfunction

    // Tail slot: (head + count) mod depth
    function automatic logic [PtrW-1:0] tail_ptr(input logic [PtrW-1:0] head,
                                                 input logic [CntW-1:0] cnt);
        logic [SumW-1:0] s;
        s = SumW'(head) + SumW'(cnt);
        if (s >= SumW'(FifoDepth)) s = s - SumW'(FifoDepth);
        return s[PtrW-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/spim_ifs.sv
// Valid/ready channel interfaces for command items and result items.
`default_nettype none

interface spim_cmd_if;
    import spim_pkg::*;

    logic              valid;
    logic              ready;
    logic [OpW-1:0]    opcode;
    logic [RegW-1:0]   reg_index;
    logic [ByteW-1:0]  write_data;
    logic              miso_level;

    modport source (output valid, opcode, reg_index, write_data, miso_level,
                    input ready);
    modport sink   (input valid, opcode, reg_index, write_data, miso_level,
                    output ready);
endinterface

interface spim_rsp_if;
    import spim_pkg::*;

    logic              valid;
    logic              ready;
    logic [ReadW-1:0]  read_data;
    logic              sclk_level;
    logic              mosi_level;
    logic              chip_select_n;

    modport source (output valid, read_data, sclk_level, mosi_level, chip_select_n,
                    input ready);
    modport sink   (input valid, read_data, sclk_level, mosi_level, chip_select_n,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/core/spi_master_fifo_controller_core.sv
// SPI master with transmit and receive byte FIFOs: top level.
//
// Channels: cmd carries one item per handshake (opcode, reg_index, write_data,
// miso_level); an item is a serial clock tick, a register read or a register
// write. rsp returns exactly one item per command with read_data and the pin
// levels (sclk, mosi, chip select) as they stand after that command.
// Configuration (clock polarity, clock phase, half period in ticks) is written
// through cfg_we / cfg_index / cfg_data; the user must do this only while no
// command is outstanding, as the block does not enforce it.
// Path: a command is taken into the queue, executed by the engine when it leaves
// the queue, and its result registered in the result register behind rsp.valid.
// Throughput: one command per cycle while rsp.ready is high; the engine owns
// both FIFOs and the shift register and executes each command as it is taken.
// A two-entry command queue separates intake from execution; when rsp.ready is
// low the result register holds, the queue fills, and cmd.ready drops once both
// entries are taken. Nothing is dropped or repeated.
// Reset clears the FIFO counts, the engine and the configuration (polarity 0,
// phase 0, half period 1) and deasserts chip select; result payload has no reset.
`default_nettype none

module spi_master_fifo_controller_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    spim_cmd_if.sink                           cmd,
    spim_rsp_if.source                         rsp,
    input  wire logic                          cfg_we,
    input  wire logic [spim_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [spim_pkg::CfgDataW-1:0] cfg_data
);
    import spim_pkg::*;

    cmd_t q_data;
    logic q_valid;
    logic q_ready;

    spim_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_data  (q_data),
        .q_valid (q_valid),
        .q_ready (q_ready)
    );

    spim_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (q_data),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

FILE: rtl/core/spim_front.sv
// Front end: accepts command items, classifies them and queues them for the engine.
`default_nettype none

module spim_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    spim_cmd_if.sink         cmd,
    output spim_pkg::cmd_t   q_data,
    output logic             q_valid,
    input  wire logic        q_ready
);
    import spim_pkg::*;

    localparam int QDepth = 2;

    cmd_t       entry_reg [QDepth];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    cmd_t       decoded;

    // Classify the incoming item
    always_comb
    begin
        decoded.data = cmd.write_data;
        decoded.miso = cmd.miso_level;
        decoded.kind = KIND_NOP;
        if (cmd.opcode == OP_TICK)
        begin
            decoded.kind = KIND_TICK;
        end
        else if (cmd.opcode == OP_READ)
        begin
            unique case (cmd.reg_index)
                REG_DATA:   decoded.kind = KIND_RD_DATA;
                REG_STATUS: decoded.kind = KIND_RD_STATUS;
                REG_FLUSH:  decoded.kind = KIND_NOP;
                REG_CONFIG: decoded.kind = KIND_RD_CFG;
            endcase
        end
        else if (cmd.opcode == OP_WRITE)
        begin
            unique case (cmd.reg_index)
                REG_DATA:   decoded.kind = KIND_WR_DATA;
                REG_STATUS: decoded.kind = KIND_WR_STATUS;
                REG_FLUSH:  decoded.kind = KIND_WR_FLUSH;
                REG_CONFIG: decoded.kind = KIND_NOP;
            endcase
        end
    end

    // Two-entry queue toward the engine
    assign cmd.ready = (count_reg != 2'(QDepth));
    assign push      = cmd.valid && cmd.ready;
    assign q_valid   = (count_reg != 2'd0);
    assign pop       = q_valid && q_ready;
    assign q_data    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue payload, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/spim_back.sv
// Back end: FIFOs, serial engine, register file and the result register.
`default_nettype none

module spim_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire spim_pkg::cmd_t               q_data,
    input  wire logic                         q_valid,
    output logic                              q_ready,
    input  wire logic                         cfg_we,
    input  wire logic [spim_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [spim_pkg::CfgDataW-1:0] cfg_data,
    spim_rsp_if.source                        rsp
);
    import spim_pkg::*;

    // FIFO storage, contents undefined until written
    logic [ByteW-1:0] tx_mem [FifoDepth];
    logic [ByteW-1:0] rx_mem [FifoDepth];

    logic [CntW-1:0]    tx_count_reg, tx_count_next;
    logic [CntW-1:0]    rx_count_reg, rx_count_next;
    logic [PtrW-1:0]    tx_head_reg, tx_head_next;
    logic [PtrW-1:0]    rx_head_reg, rx_head_next;
    logic [ByteW-1:0]   shift_reg, shift_next;
    logic [BitCntW-1:0] bit_cnt_reg, bit_cnt_next;
    logic [HalfW-1:0]   div_reg, div_next;
    logic               active_reg, active_next;
    logic               sclk_reg, sclk_next;
    logic               cs_reg, cs_next;
    logic               mosi_reg, mosi_next;

    logic               cpol_reg, cpha_reg;
    logic [HalfW-1:0]   half_reg;

    logic               out_valid_reg, out_valid_next;
    logic [ReadW-1:0]   read_data_reg;
    logic               sclk_level_reg, mosi_level_reg, cs_n_reg;

    logic               fire;
    logic [ReadW-1:0]   rd;
    logic               tx_we, rx_we;
    logic [PtrW-1:0]    tx_waddr, rx_waddr;
    logic [ByteW-1:0]   rx_wdata;
    logic [ByteW-1:0]   tx_rd, rx_rd;

    logic [HalfW-1:0]   hp_eff;
    logic [HalfW:0]     div_inc;
    logic               edge_due;
    logic [ByteW-1:0]   shifted;
    logic [ByteW-1:0]   shift_trail;
    logic [BitCntW-1:0] bit_trail;

    assign q_ready = !out_valid_reg || rsp.ready;
    assign fire    = q_valid && q_ready;

    assign tx_rd    = tx_mem[tx_head_reg];
    assign rx_rd    = rx_mem[rx_head_reg];
    assign tx_waddr = tail_ptr(tx_head_reg, tx_count_reg);
    assign rx_waddr = tail_ptr(rx_head_reg, rx_count_reg);

    // Serial clock divider and shift helpers
    assign hp_eff      = (half_reg == '0) ? HalfW'(1) : half_reg;
    assign div_inc     = {1'b0, div_reg} + (HalfW+1)'(1);
    assign edge_due    = !(div_inc < {1'b0, hp_eff});
    assign shifted     = {shift_reg[ByteW-2:0], q_data.miso};
    assign shift_trail = cpha_reg ? shifted : shift_reg;
    assign bit_trail   = cpha_reg ? (bit_cnt_reg + BitCntW'(1)) : bit_cnt_reg;

    // Execute one command
    always_comb
    begin
        tx_count_next  = tx_count_reg;
        rx_count_next  = rx_count_reg;
        tx_head_next   = tx_head_reg;
        rx_head_next   = rx_head_reg;
        shift_next     = shift_reg;
        bit_cnt_next   = bit_cnt_reg;
        div_next       = div_reg;
        active_next    = active_reg;
        sclk_next      = sclk_reg;
        cs_next        = cs_reg;
        mosi_next      = mosi_reg;
        tx_we          = 1'b0;
        rx_we          = 1'b0;
        rx_wdata       = shift_trail;
        rd             = '0;
        out_valid_next = out_valid_reg && !rsp.ready;

        if (fire)
        begin
            out_valid_next = 1'b1;
            unique case (q_data.kind)
                KIND_TICK:
                begin
                    if (!active_reg)
                    begin
                        // load next byte when idle
                        if (tx_count_reg != '0)
                        begin
                            shift_next    = tx_rd;
                            tx_head_next  = ptr_inc(tx_head_reg);
                            tx_count_next = tx_count_reg - CntW'(1);
                            bit_cnt_next  = '0;
                            div_next      = '0;
                            sclk_next     = 1'b0;
                            active_next   = 1'b1;
                            if (!cpha_reg)
                            begin
                                mosi_next = tx_rd[ByteW-1];
                            end
                        end
                    end
                    else if (!edge_due)
                    begin
                        div_next = div_inc[HalfW-1:0];
                    end
                    else
                    begin
                        div_next  = '0;
                        sclk_next = ~sclk_reg;
                        if (!sclk_reg)
                        begin
                            // leading edge
                            if (!cpha_reg)
                            begin
                                shift_next   = shifted;
                                bit_cnt_next = bit_cnt_reg + BitCntW'(1);
                            end
                            else
                            begin
                                mosi_next = shift_reg[ByteW-1];
                            end
                        end
                        else
                        begin
                            // trailing edge
                            shift_next   = shift_trail;
                            bit_cnt_next = bit_trail;
                            if (bit_trail >= BitCntW'(BitsPerByte))
                            begin
                                if (rx_count_reg != CntW'(FifoDepth))
                                begin
                                    rx_we         = 1'b1;
                                    rx_count_next = rx_count_reg + CntW'(1);
                                end
                                active_next  = 1'b0;
                                bit_cnt_next = '0;
                            end
                            else if (!cpha_reg)
                            begin
                                mosi_next = shift_trail[ByteW-1];
                            end
                        end
                    end
                end
                KIND_RD_DATA:
                begin
                    if (rx_count_reg != '0)
                    begin
                        rd            = ReadW'(rx_rd);
                        rx_head_next  = ptr_inc(rx_head_reg);
                        rx_count_next = rx_count_reg - CntW'(1);
                    end
                end
                KIND_RD_STATUS:
                begin
                    rd[ST_TXE] = (tx_count_reg == '0);
                    rd[ST_TXF] = (tx_count_reg == CntW'(FifoDepth));
                    rd[ST_RXE] = (rx_count_reg == '0);
                    rd[ST_RXF] = (rx_count_reg == CntW'(FifoDepth));
                    rd[ST_CS]  = cs_reg;
                end
                KIND_RD_CFG:
                begin
                    rd = {cpol_reg, cpha_reg, half_reg};
                end
                KIND_WR_DATA:
                begin
                    if (tx_count_reg != CntW'(FifoDepth))
                    begin
                        tx_we         = 1'b1;
                        tx_count_next = tx_count_reg + CntW'(1);
                    end
                end
                KIND_WR_STATUS:
                begin
                    cs_next = q_data.data[ST_CS];
                end
                KIND_WR_FLUSH:
                begin
                    if (q_data.data[FL_TX])
                    begin
                        tx_count_next = '0;
                        tx_head_next  = '0;
                    end
                    if (q_data.data[FL_RX])
                    begin
                        rx_count_next = '0;
                        rx_head_next  = '0;
                    end
                end
                KIND_NOP:
                begin
                end
            endcase
        end
    end

    // Engine, FIFO pointers and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_count_reg  <= '0;
            rx_count_reg  <= '0;
            tx_head_reg   <= '0;
            rx_head_reg   <= '0;
            shift_reg     <= '0;
            bit_cnt_reg   <= '0;
            div_reg       <= '0;
            active_reg    <= 1'b0;
            sclk_reg      <= 1'b0;
            cs_reg        <= 1'b0;
            mosi_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tx_count_reg  <= tx_count_next;
            rx_count_reg  <= rx_count_next;
            tx_head_reg   <= tx_head_next;
            rx_head_reg   <= rx_head_next;
            shift_reg     <= shift_next;
            bit_cnt_reg   <= bit_cnt_next;
            div_reg       <= div_next;
            active_reg    <= active_next;
            sclk_reg      <= sclk_next;
            cs_reg        <= cs_next;
            mosi_reg      <= mosi_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpol_reg <= 1'b0;
            cpha_reg <= 1'b0;
            half_reg <= HalfW'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CPOL: cpol_reg <= cfg_data[0];
                CFG_CPHA: cpha_reg <= cfg_data[0];
                CFG_HALF: half_reg <= cfg_data[HalfW-1:0];
                default:  ;
            endcase
        end
    end

    // Result payload and FIFO storage, no reset
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            read_data_reg  <= rd;
            sclk_level_reg <= cpol_reg ^ sclk_next;
            mosi_level_reg <= mosi_next;
            cs_n_reg       <= ~cs_next;
        end
        if (tx_we)
        begin
            tx_mem[tx_waddr] <= q_data.data;
        end
        if (rx_we)
        begin
            rx_mem[rx_waddr] <= rx_wdata;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.read_data     = read_data_reg;
    assign rsp.sclk_level    = sclk_level_reg;
    assign rsp.mosi_level    = mosi_level_reg;
    assign rsp.chip_select_n = cs_n_reg;

endmodule

`default_nettype wire

FILE: rtl/core/spim_checker.sv
// Port-level checks of the SPI master top level, bound to it.
`default_nettype none

module spim_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        cmd_valid,
    input wire logic                        cmd_ready,
    input wire logic                        rsp_valid,
    input wire logic                        rsp_ready,
    input wire logic [spim_pkg::ReadW-1:0]  read_data,
    input wire logic                        sclk_level,
    input wire logic                        mosi_level,
    input wire logic                        chip_select_n
);
    import spim_pkg::*;

    // Items taken but not yet delivered: queue plus result register
    logic [2:0] pending_reg, pending_next;
    logic       cmd_take, rsp_take;

    assign cmd_take     = cmd_valid && cmd_ready;
    assign rsp_take     = rsp_valid && rsp_ready;
    assign pending_next = pending_reg + 3'(cmd_take) - 3'(rsp_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 3'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(read_data) && $stable(sclk_level)
                                    && $stable(mosi_level) && $stable(chip_select_n))
        else $error("result payload changed while stalled");

    // No result without an outstanding command
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 3'd0)
        else $error("result without a pending command");

    // Never more in flight than queue and result register hold
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd3)
        else $error("too many commands in flight");

endmodule

bind spi_master_fifo_controller_core spim_checker u_spim_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .read_data     (rsp.read_data),
    .sclk_level    (rsp.sclk_level),
    .mosi_level    (rsp.mosi_level),
    .chip_select_n (rsp.chip_select_n)
);

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the SPI master with byte FIFOs: directed and random bus traffic.
`timescale 1ns / 100ps

module tb_top;
    import spim_pkg::*;

    // Opcode with no action; only the pins are reported
    localparam logic [OpW-1:0] OP_NONE = 2'd3;
    localparam int MaxHalf = 65535;
    localparam int TotalItems = 1050;
    localparam int RandomPhases = 8;

    typedef struct packed {
        logic [ReadW-1:0] read_data;
        logic             sclk_level;
        logic             mosi_level;
        logic             chip_select_n;
    } spi_reply_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    spim_cmd_if cmd_ch();
    spim_rsp_if rsp_ch();

    spi_master_fifo_controller_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state: FIFOs, serial engine, pins and mode
    logic [ByteW-1:0] tx_bytes [FifoDepth];
    logic [ByteW-1:0] rx_bytes [FifoDepth];
    logic [CntW-1:0]  tx_fill, rx_fill;
    logic [PtrW-1:0]  tx_rd_ptr, rx_rd_ptr;
    logic [ByteW-1:0] shifter;
    int               bits_done;
    int               div_ticks;
    logic             busy, sclk_phase, cs_on, mosi_out;
    logic             mode_cpol, mode_cpha;
    logic [HalfW-1:0] mode_half;

    spi_reply_t predicted_replies[$];
    spi_reply_t want;
    int         mismatch_count = 0;
    int         cmd_calm = 0;
    int         rsp_calm = 0;
    int         stall_left = 0;
    int         items_sent = 0;

    task automatic reset_spi_state();
        tx_fill    = '0;
        rx_fill    = '0;
        tx_rd_ptr  = '0;
        rx_rd_ptr  = '0;
        shifter    = '0;
        bits_done  = 0;
        div_ticks  = 0;
        busy       = 1'b0;
        sclk_phase = 1'b0;
        cs_on      = 1'b0;
        mosi_out   = 1'b0;
        mode_cpol  = 1'b0;
        mode_cpha  = 1'b0;
        mode_half  = HalfW'(1);
    endtask

    // One serial clock tick of the engine
    function automatic void step_serial_engine(input logic miso);
        int hp;
        hp = (mode_half == '0) ? 1 : int'(mode_half);
        if (!busy) begin
            // idle: load the next byte if there is one
            if (tx_fill != '0) begin
                shifter    = tx_bytes[tx_rd_ptr];
                tx_rd_ptr  = PtrW'((int'(tx_rd_ptr) + 1) % FifoDepth);
                tx_fill    = tx_fill - 1'b1;
                bits_done  = 0;
                div_ticks  = 0;
                sclk_phase = 1'b0;
                busy       = 1'b1;
                if (!mode_cpha)
                    mosi_out = shifter[ByteW-1];
            end
            return;
        end
        if (div_ticks + 1 < hp) begin
            div_ticks++;
            return;
        end
        div_ticks  = 0;
        sclk_phase = ~sclk_phase;
        if (sclk_phase) begin
            // leading edge
            if (!mode_cpha) begin
                shifter = {shifter[ByteW-2:0], miso};
                bits_done++;
            end else begin
                mosi_out = shifter[ByteW-1];
            end
        end else begin
            // trailing edge
            if (mode_cpha) begin
                shifter = {shifter[ByteW-2:0], miso};
                bits_done++;
            end
            if (bits_done >= BitsPerByte) begin
                // byte done; dropped when the receive FIFO is full
                if (rx_fill < FifoDepth) begin
                    rx_bytes[(int'(rx_rd_ptr) + int'(rx_fill)) % FifoDepth] = shifter;
                    rx_fill = rx_fill + 1'b1;
                end
                busy      = 1'b0;
                bits_done = 0;
            end else if (!mode_cpha) begin
                mosi_out = shifter[ByteW-1];
            end
        end
    endfunction

    // Expected reply to one bus item; updates the predictor state
    function automatic spi_reply_t predict_reply(input logic [OpW-1:0] op,
                                                 input logic [RegW-1:0] ri,
                                                 input logic [ByteW-1:0] wd,
                                                 input logic miso);
        logic [ReadW-1:0] rd;
        spi_reply_t       r;
        rd = '0;
        case (op)
            OP_TICK: step_serial_engine(miso);
            OP_READ:
                case (ri)
                    REG_DATA:
                        if (rx_fill != '0) begin
                            rd        = ReadW'(rx_bytes[rx_rd_ptr]);
                            rx_rd_ptr = PtrW'((int'(rx_rd_ptr) + 1) % FifoDepth);
                            rx_fill   = rx_fill - 1'b1;
                        end
                    REG_STATUS: begin
                        rd[ST_TXE] = (tx_fill == '0);
                        rd[ST_TXF] = (tx_fill >= FifoDepth);
                        rd[ST_RXE] = (rx_fill == '0);
                        rd[ST_RXF] = (rx_fill >= FifoDepth);
                        rd[ST_CS]  = cs_on;
                    end
                    REG_CONFIG: rd = {mode_cpol, mode_cpha, mode_half};
                    default: ;
                endcase
            OP_WRITE:
                case (ri)
                    REG_DATA:
                        if (tx_fill < FifoDepth) begin
                            tx_bytes[(int'(tx_rd_ptr) + int'(tx_fill)) % FifoDepth] = wd;
                            tx_fill = tx_fill + 1'b1;
                        end
                    REG_STATUS: cs_on = wd[ST_CS];
                    REG_FLUSH: begin
                        if (wd[FL_TX]) begin
                            tx_fill   = '0;
                            tx_rd_ptr = '0;
                        end
                        if (wd[FL_RX]) begin
                            rx_fill   = '0;
                            rx_rd_ptr = '0;
                        end
                    end
                    default: ;
                endcase
            default: ;
        endcase
        r.read_data     = rd;
        r.sclk_level    = mode_cpol ^ sclk_phase;
        r.mosi_level    = mosi_out;
        r.chip_select_n = ~cs_on;
        return r;
    endfunction

    // Gap length: mostly none or short, a few long, with calm stretches
    function automatic int draw_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    // Send one item, predict its reply at acceptance, then maybe idle
    task automatic issue_bus_op(input logic [OpW-1:0] op, input logic [RegW-1:0] ri,
                                input logic [ByteW-1:0] wd, input logic miso);
        int gap;
        cmd_ch.valid      <= 1'b1;
        cmd_ch.opcode     <= op;
        cmd_ch.reg_index  <= ri;
        cmd_ch.write_data <= wd;
        cmd_ch.miso_level <= miso;
        @(posedge clk);
        while (cmd_ch.ready !== 1'b1) @(posedge clk);
        predicted_replies.push_back(predict_reply(op, ri, wd, miso));
        items_sent++;
        gap = draw_gap(cmd_calm);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic reg_read(input logic [RegW-1:0] ri);
        issue_bus_op(OP_READ, ri, ByteW'($urandom), 1'($urandom));
    endtask

    task automatic reg_write(input logic [RegW-1:0] ri, input logic [ByteW-1:0] wd);
        issue_bus_op(OP_WRITE, ri, wd, 1'($urandom));
    endtask

    // Ticks with random miso and random unused fields
    task automatic tick_burst(input int n);
        repeat (n) issue_bus_op(OP_TICK, RegW'($urandom), ByteW'($urandom), 1'($urandom));
    endtask

    // Tick until the engine is idle and the transmit FIFO is empty
    task automatic drain_engine();
        while (busy || tx_fill != '0) tick_burst(1);
    endtask

    // Stop sending and wait for every outstanding reply
    task automatic wait_quiet();
        cmd_ch.valid <= 1'b0;
        while (predicted_replies.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_spi_mode(input logic cpol, input logic cpha, input int half);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CPOL;
        cfg_data  <= CfgDataW'(cpol);
        @(posedge clk);
        cfg_index <= CFG_CPHA;
        cfg_data  <= CfgDataW'(cpha);
        @(posedge clk);
        cfg_index <= CFG_HALF;
        cfg_data  <= CfgDataW'(half);
        @(posedge clk);
        cfg_we    <= 1'b0;
        mode_cpol = cpol;
        mode_cpha = cpha;
        mode_half = HalfW'(half);
    endtask

    // One random item of any kind
    task automatic noise_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)      tick_burst(1);
        else if (r < 67) reg_write(REG_DATA, ByteW'($urandom));
        else if (r < 77) reg_read(REG_DATA);
        else if (r < 84) reg_read(REG_STATUS);
        else if (r < 87) reg_read(REG_CONFIG);
        else if (r < 90) reg_write(REG_STATUS, ByteW'($urandom));
        else if (r < 92) reg_write(REG_FLUSH, ByteW'($urandom));
        else if (r < 96) begin
            // ignored: config write via the bus, flush readback
            if (r < 94) reg_write(REG_CONFIG, ByteW'($urandom));
            else        reg_read(REG_FLUSH);
        end else begin
            issue_bus_op(OP_NONE, RegW'($urandom), ByteW'($urandom), 1'($urandom));
        end
    endtask

    // Registers after reset, ignored accesses, unused opcode
    task automatic test_reset_values();
        reg_read(REG_STATUS);
        reg_read(REG_CONFIG);
        reg_read(REG_DATA);
        reg_read(REG_FLUSH);
        reg_write(REG_CONFIG, 8'hFF);
        reg_read(REG_CONFIG);
        issue_bus_op(OP_NONE, REG_DATA, 8'hFF, 1'b1);
        issue_bus_op(OP_NONE, REG_CONFIG, 8'h00, 1'b0);
    endtask

    task automatic test_chip_select();
        reg_write(REG_STATUS, 8'hFF);
        reg_read(REG_STATUS);
        reg_write(REG_STATUS, 8'hFE);
        reg_read(REG_STATUS);
        reg_write(REG_STATUS, 8'h01);
    endtask

    // All clock modes (polarity and phase), smallest and largest half period
    task automatic test_clock_modes();
        int m;
        for (m = 0; m < 4; m++) begin
            set_spi_mode(m[1], m[0], 1 + m % 2);
            reg_write(REG_DATA, 8'hA5 ^ ByteW'(m));
            drain_engine();
            reg_read(REG_DATA);
        end
        set_spi_mode(1'b1, 1'b0, 0);
        reg_read(REG_CONFIG);
        reg_write(REG_DATA, 8'h5A);
        drain_engine();
        reg_read(REG_DATA);
        // no transfer under the largest half period: the run would be far too long
        set_spi_mode(1'b1, 1'b1, MaxHalf);
        reg_read(REG_CONFIG);
        tick_burst(3);
        reg_read(REG_STATUS);
    endtask

    // Full transmit FIFO, full receive FIFO, read of an empty FIFO
    task automatic test_fifo_limits();
        int i;
        set_spi_mode(1'b0, 1'b0, 1);
        reg_write(REG_DATA, 8'h00);
        reg_write(REG_DATA, 8'hFF);
        reg_write(REG_DATA, 8'h80);
        reg_write(REG_DATA, 8'h01);
        for (i = 0; i < 5; i++) reg_write(REG_DATA, ByteW'($urandom));
        reg_read(REG_STATUS);
        drain_engine();
        reg_read(REG_STATUS);
        reg_write(REG_DATA, 8'h3C);
        drain_engine();
        for (i = 0; i < 9; i++) reg_read(REG_DATA);
        reg_read(REG_STATUS);
    endtask

    // Flush of the transmit FIFO during a transfer, then of the receive FIFO, then both
    task automatic test_flush();
        reg_write(REG_DATA, 8'hC3);
        reg_write(REG_DATA, 8'h96);
        reg_write(REG_DATA, 8'h69);
        tick_burst(5);
        reg_write(REG_FLUSH, 8'h02);
        reg_read(REG_STATUS);
        drain_engine();
        reg_read(REG_STATUS);
        reg_write(REG_FLUSH, 8'h01);
        reg_read(REG_STATUS);
        reg_read(REG_DATA);
        reg_write(REG_DATA, 8'h0F);
        drain_engine();
        reg_write(REG_FLUSH, 8'h03);
        reg_read(REG_STATUS);
    endtask

    // Random phases: mostly write/shift/read exchanges, some noise
    task automatic test_random_traffic();
        int phase, k, ticks, hp, n, half, phase_end;
        for (phase = 0; phase < RandomPhases; phase++) begin
            drain_engine();
            if (phase == 3)      half = 0;
            else if (phase == 5) half = 3;
            else                 half = $urandom_range(1, 2);
            set_spi_mode(1'($urandom), 1'($urandom), half);
            hp = (half == 0) ? 1 : half;
            // share what is left of the item budget among the remaining phases
            phase_end = items_sent + (TotalItems - items_sent) / (RandomPhases - phase);
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 9) < 7) begin
                    if (hp <= 2 && $urandom_range(0, 5) == 0) k = $urandom_range(7, 10);
                    else                                       k = $urandom_range(1, 3);
                    for (n = 0; n < k; n++) reg_write(REG_DATA, ByteW'($urandom));
                    ticks = k * (2 * BitsPerByte * hp + 1);
                    // sometimes stop mid-transfer
                    if ($urandom_range(0, 3) == 0) ticks = $urandom_range(1, ticks);
                    else                           ticks += $urandom_range(0, 4);
                    // stay within the phase budget, even mid-transfer
                    if (ticks > phase_end - items_sent) ticks = phase_end - items_sent;
                    for (n = 0; n < ticks; n++) begin
                        if ($urandom_range(0, 15) == 0) reg_read(REG_STATUS);
                        tick_burst(1);
                    end
                    for (n = 0; n <= k; n++) reg_read(REG_DATA);
                    reg_read(REG_STATUS);
                end else begin
                    repeat ($urandom_range(5, 25)) noise_item();
                end
            end
        end
    endtask

    // Reply channel backpressure
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
                stall_left = draw_gap(rsp_calm);
            end
        end
    end

    // Compare each reply with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (predicted_replies.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected reply, expected none, actual %h", $time,
                         {rsp_ch.read_data, rsp_ch.sclk_level, rsp_ch.mosi_level,
                          rsp_ch.chip_select_n});
            end else begin
                want = predicted_replies.pop_front();
                if (rsp_ch.read_data !== want.read_data) begin
                    mismatch_count++;
                    $display("%0t: read_data expected %h actual %h", $time,
                             want.read_data, rsp_ch.read_data);
                end
                if (rsp_ch.sclk_level !== want.sclk_level) begin
                    mismatch_count++;
                    $display("%0t: sclk_level expected %b actual %b", $time,
                             want.sclk_level, rsp_ch.sclk_level);
                end
                if (rsp_ch.mosi_level !== want.mosi_level) begin
                    mismatch_count++;
                    $display("%0t: mosi_level expected %b actual %b", $time,
                             want.mosi_level, rsp_ch.mosi_level);
                end
                if (rsp_ch.chip_select_n !== want.chip_select_n) begin
                    mismatch_count++;
                    $display("%0t: chip_select_n expected %b actual %b", $time,
                             want.chip_select_n, rsp_ch.chip_select_n);
                end
            end
        end
    end

    // Test sequence
    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_CPOL;
        cfg_data          <= '0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.opcode     <= OP_TICK;
        cmd_ch.reg_index  <= REG_DATA;
        cmd_ch.write_data <= '0;
        cmd_ch.miso_level <= 1'b0;
        reset_spi_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_chip_select();
        test_clock_modes();
        test_fifo_limits();
        test_flush();
        test_random_traffic();

        wait_quiet();
        repeat (6) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
